// ===== design/hbe_pkg.sv =====
// shared constants, types and sequencer states for the histogram bar and exposure block
// no dependencies
package hbe_pkg;

    localparam int COUNT_BITS   = 24;
    localparam int BIN_COUNT    = 256;
    localparam int BIN_W        = 8;
    localparam int HEIGHT_W     = 9;
    localparam int EXPO_W       = 8;
    localparam int QUO_W        = 11;
    localparam int CNT_W        = $clog2(QUO_W);
    localparam int UNIT_W       = COUNT_BITS + QUO_W;

    localparam int DARK_END     = 30;
    localparam int MED_LO       = 112;
    localparam int MED_END      = 142;
    localparam int BRIGHT_LO    = 226;
    localparam int LAST_BIN     = BIN_COUNT - 1;
    localparam int HEIGHT_MAX   = 256;
    localparam int EXPO_NEUTRAL = 100;
    localparam int BAR_SCALE    = 255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_STORE,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE,
        CH_EXPO
    } chan_t;

endpackage

// ===== design/histogram_bar_and_exposure.sv =====
// histogram bar heights and exposure meter, top level
// a new bin is taken only when the sequencer is idle, after the previous bin has finished;
// a shared 11-step restoring divider runs once per channel unless the peak count is zero,
//   and once more for exposure on the last bin unless the dark and bright sums are both zero
// reset: asynchronous active-low rst_n clears sequencer, region sums and output valid
// depends on hbe_pkg
module histogram_bar_and_exposure
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hbe_pkg::BIN_W-1:0]     bin_index,
    input  logic [hbe_pkg::COUNT_BITS-1:0] red_count,
    input  logic [hbe_pkg::COUNT_BITS-1:0] green_count,
    input  logic [hbe_pkg::COUNT_BITS-1:0] blue_count,
    input  logic [hbe_pkg::COUNT_BITS-1:0] peak_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hbe_pkg::BIN_W-1:0]     out_bin,
    output logic [hbe_pkg::HEIGHT_W-1:0]  red_height,
    output logic [hbe_pkg::HEIGHT_W-1:0]  green_height,
    output logic [hbe_pkg::HEIGHT_W-1:0]  blue_height,
    output logic                          peak_zero,
    output logic [hbe_pkg::COUNT_BITS-1:0] dark_total,
    output logic [hbe_pkg::COUNT_BITS-1:0] medium_total,
    output logic [hbe_pkg::COUNT_BITS-1:0] bright_total,
    output logic [hbe_pkg::EXPO_W-1:0]    exposure,
    output logic                          frame_done
);
    import hbe_pkg::*;

    state_t                  state_reg, state_next;
    chan_t                   ch_reg, ch_next, ch_adv;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [UNIT_W-1:0]       rem_reg, rem_next;
    logic [UNIT_W-1:0]       div_reg, div_next;
    logic [QUO_W-1:0]        quo_reg, quo_next;

    logic [BIN_W-1:0]        bin_reg, bin_next;
    logic [COUNT_BITS-1:0]   red_reg, red_next;
    logic [COUNT_BITS-1:0]   green_reg, green_next;
    logic [COUNT_BITS-1:0]   blue_reg, blue_next;
    logic [COUNT_BITS-1:0]   peak_reg, peak_next;
    logic                    last_reg, last_next;

    logic [COUNT_BITS-1:0]   dark_reg, dark_next;
    logic [COUNT_BITS-1:0]   medium_reg, medium_next;
    logic [COUNT_BITS-1:0]   bright_reg, bright_next;

    logic [HEIGHT_W-1:0]     red_h_reg, red_h_next;
    logic [HEIGHT_W-1:0]     green_h_reg, green_h_next;
    logic [HEIGHT_W-1:0]     blue_h_reg, blue_h_next;
    logic [EXPO_W-1:0]       expo_reg, expo_next;

    logic                    out_valid_reg, out_valid_next;
    logic [BIN_W-1:0]        out_bin_reg, out_bin_next;
    logic [HEIGHT_W-1:0]     out_red_reg, out_red_next;
    logic [HEIGHT_W-1:0]     out_green_reg, out_green_next;
    logic [HEIGHT_W-1:0]     out_blue_reg, out_blue_next;
    logic                    out_pz_reg, out_pz_next;
    logic [COUNT_BITS-1:0]   out_dark_reg, out_dark_next;
    logic [COUNT_BITS-1:0]   out_medium_reg, out_medium_next;
    logic [COUNT_BITS-1:0]   out_bright_reg, out_bright_next;
    logic [EXPO_W-1:0]       out_expo_reg, out_expo_next;
    logic                    out_done_reg, out_done_next;

    logic                    in_xfer;
    logic                    out_load;
    logic                    peak_is_zero;
    logic                    step_done;
    logic                    skip_expo;
    logic                    skip_height;

    logic                    in_dark, in_medium, in_bright;
    logic [COUNT_BITS-1:0]   add_base, add_sat;
    logic [COUNT_BITS:0]     add_full;

    logic [COUNT_BITS-1:0]   cnt_sel;
    logic [COUNT_BITS+7:0]   numer_height;
    logic                    expo_neg;
    logic [COUNT_BITS-1:0]   expo_max, expo_diff;
    logic [COUNT_BITS+6:0]   expo_num;
    logic                    div_ge;
    logic [HEIGHT_W-1:0]     height_sat;

    // handshake and control outputs
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        in_xfer  = in_valid && in_ready;
        out_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    end

    assign peak_is_zero = (peak_reg == '0);
    assign step_done    = (cnt_reg == CNT_W'(QUO_W - 1));
    assign skip_expo    = (ch_reg == CH_EXPO) && (expo_max == '0);
    assign skip_height  = (ch_reg != CH_EXPO) && peak_is_zero;
    assign ch_adv       = chan_t'(ch_reg + 2'd1);

    // region sums, one saturating adder
    always_comb
    begin
        in_dark   = (bin_index < BIN_W'(DARK_END));
        in_medium = (bin_index inside {[MED_LO:MED_END-1]});
        in_bright = (bin_index inside {[BRIGHT_LO:LAST_BIN]});
        if (in_dark)
        begin
            add_base = (bin_index == '0) ? '0 : dark_reg;
        end
        else if (in_medium)
        begin
            add_base = medium_reg;
        end
        else
        begin
            add_base = bright_reg;
        end
        add_full = {1'b0, add_base} + {1'b0, blue_count};
        add_sat  = add_full[COUNT_BITS] ? '1 : add_full[COUNT_BITS-1:0];
    end

    // dividend and divisor preparation
    always_comb
    begin
        case (ch_reg)
            CH_RED:   cnt_sel = red_reg;
            CH_GREEN: cnt_sel = green_reg;
            default:  cnt_sel = blue_reg;
        endcase
        numer_height = {cnt_sel, 8'b0} - {8'b0, cnt_sel};
        expo_neg  = (dark_reg > bright_reg);
        expo_max  = expo_neg ? dark_reg : bright_reg;
        expo_diff = expo_neg ? (dark_reg - bright_reg) : (bright_reg - dark_reg);
        expo_num  = {7'b0, expo_diff} * (COUNT_BITS+7)'(EXPO_NEUTRAL);
        div_ge    = (rem_reg >= div_reg);
        height_sat = (quo_reg > QUO_W'(HEIGHT_MAX)) ? HEIGHT_W'(HEIGHT_MAX)
                                                     : quo_reg[HEIGHT_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (skip_expo)
                begin
                    state_next = ST_FINISH;
                end
                else if (skip_height)
                begin
                    if (ch_reg == CH_BLUE && !last_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (step_done)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                if (ch_reg == CH_EXPO || (ch_reg == CH_BLUE && !last_reg))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        ch_next      = ch_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        quo_next     = quo_reg;
        bin_next     = bin_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        peak_next    = peak_reg;
        last_next    = last_reg;
        dark_next    = dark_reg;
        medium_next  = medium_reg;
        bright_next  = bright_reg;
        red_h_next   = red_h_reg;
        green_h_next = green_h_reg;
        blue_h_next  = blue_h_reg;
        expo_next    = expo_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    bin_next   = bin_index;
                    red_next   = red_count;
                    green_next = green_count;
                    blue_next  = blue_count;
                    peak_next  = peak_count;
                    last_next  = (bin_index == BIN_W'(LAST_BIN));
                    ch_next    = CH_RED;
                    expo_next  = EXPO_W'(EXPO_NEUTRAL);
                    if (bin_index == '0)
                    begin
                        medium_next = '0;
                        bright_next = '0;
                    end
                    if (in_dark)
                    begin
                        dark_next = add_sat;
                    end
                    else if (in_medium)
                    begin
                        medium_next = add_sat;
                    end
                    else if (in_bright)
                    begin
                        bright_next = add_sat;
                    end
                end
            end
            ST_LOAD:
            begin
                cnt_next = '0;
                quo_next = '0;
                if (skip_expo)
                begin
                    expo_next = EXPO_W'(EXPO_NEUTRAL);
                end
                else if (skip_height)
                begin
                    case (ch_reg)
                        CH_RED:   red_h_next   = '0;
                        CH_GREEN: green_h_next = '0;
                        default:  blue_h_next  = '0;
                    endcase
                    ch_next = ch_adv;
                end
                else if (ch_reg == CH_EXPO)
                begin
                    rem_next = UNIT_W'(expo_num);
                    div_next = UNIT_W'({expo_max, {(QUO_W-1){1'b0}}});
                end
                else
                begin
                    rem_next = UNIT_W'(numer_height);
                    div_next = UNIT_W'({peak_reg, {(QUO_W-1){1'b0}}});
                end
            end
            ST_STEP:
            begin
                rem_next = div_ge ? (rem_reg - div_reg) : rem_reg;
                div_next = div_reg >> 1;
                quo_next = {quo_reg[QUO_W-2:0], div_ge};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_STORE:
            begin
                case (ch_reg)
                    CH_RED:   red_h_next   = height_sat;
                    CH_GREEN: green_h_next = height_sat;
                    CH_BLUE:  blue_h_next  = height_sat;
                    default:
                    begin
                        expo_next = expo_neg
                            ? EXPO_W'(EXPO_NEUTRAL) - quo_reg[EXPO_W-1:0]
                            : EXPO_W'(EXPO_NEUTRAL) + quo_reg[EXPO_W-1:0];
                    end
                endcase
                ch_next = ch_adv;
            end
            default:
            begin
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_bin_next    = out_bin_reg;
        out_red_next    = out_red_reg;
        out_green_next  = out_green_reg;
        out_blue_next   = out_blue_reg;
        out_pz_next     = out_pz_reg;
        out_dark_next   = out_dark_reg;
        out_medium_next = out_medium_reg;
        out_bright_next = out_bright_reg;
        out_expo_next   = out_expo_reg;
        out_done_next   = out_done_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_bin_next    = bin_reg;
            out_red_next    = red_h_reg;
            out_green_next  = green_h_reg;
            out_blue_next   = blue_h_reg;
            out_pz_next     = peak_is_zero;
            out_dark_next   = last_reg ? dark_reg : '0;
            out_medium_next = last_reg ? medium_reg : '0;
            out_bright_next = last_reg ? bright_reg : '0;
            out_expo_next   = last_reg ? expo_reg : '0;
            out_done_next   = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= CH_RED;
            cnt_reg       <= '0;
            dark_reg      <= '0;
            medium_reg    <= '0;
            bright_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
            dark_reg      <= dark_next;
            medium_reg    <= medium_next;
            bright_reg    <= bright_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        quo_reg        <= quo_next;
        bin_reg        <= bin_next;
        red_reg        <= red_next;
        green_reg      <= green_next;
        blue_reg       <= blue_next;
        peak_reg       <= peak_next;
        last_reg       <= last_next;
        red_h_reg      <= red_h_next;
        green_h_reg    <= green_h_next;
        blue_h_reg     <= blue_h_next;
        expo_reg       <= expo_next;
        out_bin_reg    <= out_bin_next;
        out_red_reg    <= out_red_next;
        out_green_reg  <= out_green_next;
        out_blue_reg   <= out_blue_next;
        out_pz_reg     <= out_pz_next;
        out_dark_reg   <= out_dark_next;
        out_medium_reg <= out_medium_next;
        out_bright_reg <= out_bright_next;
        out_expo_reg   <= out_expo_next;
        out_done_reg   <= out_done_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_bin      = out_bin_reg;
    assign red_height   = out_red_reg;
    assign green_height = out_green_reg;
    assign blue_height  = out_blue_reg;
    assign peak_zero    = out_pz_reg;
    assign dark_total   = out_dark_reg;
    assign medium_total = out_medium_reg;
    assign bright_total = out_bright_reg;
    assign exposure     = out_expo_reg;
    assign frame_done   = out_done_reg;

`ifndef NO_ASSERTIONS
    a_step_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (cnt_reg <= CNT_W'(QUO_W - 1)))
        else $error("divider step count overran");

    a_busy_after_xfer : assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input taken again before the bin finished");

    a_height_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red_height <= HEIGHT_W'(HEIGHT_MAX))
                   && (green_height <= HEIGHT_W'(HEIGHT_MAX))
                   && (blue_height <= HEIGHT_W'(HEIGHT_MAX)))
        else $error("bar height above saturation");

    a_zero_peak : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && peak_zero) |-> (red_height == '0) && (green_height == '0)
                                  && (blue_height == '0))
        else $error("nonzero height with zero peak");

    a_not_last : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_done) |-> (exposure == '0) && (dark_total == '0)
                                    && (medium_total == '0) && (bright_total == '0))
        else $error("totals reported before the last bin");

    a_expo_range : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> (exposure <= EXPO_W'(2 * EXPO_NEUTRAL)))
        else $error("exposure out of range");
`endif

endmodule
